### rtl/tcpcc_pkg.sv
// Shared types, widths and constants for the TCP congestion and RTO controller.
// Used by tcpcc_ctrl, tcpcc_dp and tcp_congestion_and_rto_control; no dependencies.
package tcpcc_pkg;

	localparam int WIN_FRAC_BITS = 16;
	localparam int RTT_BITS      = 16;

	localparam int WIN_W    = 32;
	localparam int SS_W     = 16;
	localparam int RTO_W    = 24;
	localparam int MINRTO_W = 16;
	localparam int SEG_W    = 16;
	localparam int ACK_W    = 32;
	localparam int SAMPLE_W = 16;
	localparam int SEGS_W   = 16;
	localparam int HIST_W   = ACK_W + 1;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	// The reciprocal 2^(2F) / cwnd has 2F+1 quotient bits, one per divider step.
	localparam int DIV_W     = 2 * WIN_FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int INC_W     = (DIV_W > WIN_W) ? DIV_W : WIN_W;
	localparam int SUM_W     = INC_W + 1;
	localparam int RTOC_W    = (RTT_BITS + 3 > RTO_W) ? RTT_BITS + 3 : RTO_W + 1;

	localparam logic [WIN_W-1:0]    WIN_ONE = WIN_W'(64'd1 << WIN_FRAC_BITS);
	localparam logic [WIN_W-1:0]    WIN_MAX = '1;
	localparam logic [SS_W-1:0]     SS_MAX  = '1;
	localparam logic [SS_W-1:0]     SS_MIN  = SS_W'(2);
	localparam logic [RTO_W-1:0]    RTO_MAX = '1;
	localparam logic [SEGS_W-1:0]   SEGS_MAX = '1;
	localparam logic [RTT_BITS-1:0] RTT_MAX = '1;

	localparam logic [SS_W-1:0]     SSTHRESH_RST = SS_W'(64);
	localparam logic [RTO_W-1:0]    RTO_RST      = RTO_W'(3000);
	localparam logic [MINRTO_W-1:0] MIN_RTO_RST  = MINRTO_W'(10);
	localparam logic [SEG_W-1:0]    SEG_SIZE_RST = SEG_W'(1024);

	localparam logic CMD_ACK     = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		REG_SSTHRESH = 2'd0,
		REG_INIT_RTO = 2'd1,
		REG_MIN_RTO  = 2'd2,
		REG_SEG_SIZE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                wr_ssthresh;
		logic                wr_rto;
		logic [SS_W-1:0]     ssthresh_val;
		logic [RTO_W-1:0]    rto_val;
		logic [MINRTO_W-1:0] min_rto;
		logic [SEG_W-1:0]    seg_size;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic srtt;
		logic rttvar;
		logic rto;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic is_timeout;
		logic need_div;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/tcpcc_ctrl.sv
// Sequencer for the TCP congestion and RTO controller.
// Depends on tcpcc_pkg; drives the command struct of tcpcc_dp.
module tcpcc_ctrl import tcpcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRTT,
		S_VAR,
		S_RTO,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.srtt     = (state_q == S_SRTT) && !status.is_timeout;
		cmd.rttvar   = (state_q == S_VAR);
		cmd.rto      = (state_q == S_RTO);
		cmd.div_step = (state_q == S_DIV) && !status.div_done;
		cmd.finish   = (state_q == S_FIN) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SRTT;
				end
				S_SRTT: begin
					// A timeout leaves the estimators alone and goes straight to commit.
					state_q <= status.is_timeout ? S_FIN : S_VAR;
				end
				S_VAR: state_q <= S_RTO;
				S_RTO: state_q <= status.need_div ? S_DIV : S_FIN;
				S_DIV: begin
					if (status.div_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/tcpcc_dp.sv
// Datapath of the TCP congestion and RTO controller: RTT estimators, window,
// threshold, acknowledgement history, bit-serial reciprocal divider and result register.
// Depends on tcpcc_pkg; sequenced by tcpcc_ctrl.
module tcpcc_dp import tcpcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	input  cfg_t                cfg,
	input  logic                in_cmd,
	input  logic [ACK_W-1:0]    in_ack,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WIN_W-1:0]    out_window_fixed,
	output logic [SEGS_W-1:0]   out_window_segments,
	output logic [SS_W-1:0]     out_ssthresh,
	output logic [RTO_W-1:0]    out_rto,
	output logic                out_fast,
	output logic                out_resend,
	output logic [ACK_W-1:0]    out_highest_ack
);

	// Captured item
	logic                cmd_q;
	logic [ACK_W-1:0]    ack_q;
	logic [RTT_BITS-1:0] sample_q;

	// Connection state
	logic [RTT_BITS-1:0] srtt_q;
	logic [RTT_BITS-1:0] rttvar_q;
	logic [RTO_W-1:0]    rto_q;
	logic [SS_W-1:0]     ssthresh_q;
	logic [1:0]          streak_q;
	logic [WIN_W-1:0]    cwnd_q;
	logic [HIST_W-1:0]   hist_q [3];
	logic [ACK_W-1:0]    snd_una_q;

	// Divider
	logic [WIN_W-1:0]     div_rem_q;
	logic [DIV_W-1:0]     div_quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic out_valid_q;

	// Sample saturation
	logic [RTT_BITS-1:0] sample_sat;
	assign sample_sat = (32'(in_sample) > 32'(RTT_MAX)) ? RTT_MAX : RTT_BITS'(in_sample);

	// Estimator arithmetic, one step per state
	logic [RTT_BITS+2:0] srtt_sum;
	logic [RTT_BITS-1:0] rtt_diff;
	logic [RTT_BITS+1:0] var_sum;
	logic [RTT_BITS+2:0] rto_raw;
	logic [RTOC_W-1:0]   rto_ext;
	logic [RTOC_W-1:0]   rto_bound;
	logic [RTO_W-1:0]    rto_calc;

	assign srtt_sum = ({srtt_q, 3'b000} - {3'b000, srtt_q}) + {3'b000, sample_q};
	assign rtt_diff = (srtt_q >= sample_q) ? (srtt_q - sample_q) : (sample_q - srtt_q);
	assign var_sum  = ({1'b0, rttvar_q, 1'b0} + {2'b00, rttvar_q}) + {2'b00, rtt_diff};
	assign rto_raw  = {3'b000, srtt_q} + {1'b0, rttvar_q, 2'b00};
	assign rto_ext  = RTOC_W'(rto_raw);
	assign rto_bound = (rto_ext < RTOC_W'(cfg.min_rto)) ? RTOC_W'(cfg.min_rto) : rto_ext;
	assign rto_calc = (rto_bound > RTOC_W'(RTO_MAX)) ? RTO_MAX : RTO_W'(rto_bound);

	// Fourth equal acknowledgement
	logic [HIST_W-1:0] ack_off;
	logic              fast_hit;
	assign ack_off  = {1'b0, ack_q} - HIST_W'(cfg.seg_size);
	assign fast_hit = (cmd_q == CMD_ACK) && (ack_off == hist_q[0]) &&
		(hist_q[0] == hist_q[1]) && (hist_q[1] == hist_q[2]);

	// Window arithmetic
	logic [WIN_W-1:0] whole;
	logic             ss_grow;
	logic [WIN_W-1:0] half;
	logic [SS_W-1:0]  ss_collapse;
	logic [INC_W-1:0] inc;
	logic [SUM_W-1:0] cwnd_sum;
	logic [WIN_W-1:0] cwnd_grow;

	assign whole      = cwnd_q >> WIN_FRAC_BITS;
	assign ss_grow    = (whole <= WIN_W'(ssthresh_q));
	assign half       = cwnd_q >> (WIN_FRAC_BITS + 1);
	assign ss_collapse = (half < WIN_W'(SS_MIN)) ? SS_MIN :
		(half > WIN_W'(SS_MAX)) ? SS_MAX : SS_W'(half);
	assign inc = ss_grow ? INC_W'(WIN_ONE) :
		(cwnd_q == '0) ? INC_W'(WIN_MAX) : INC_W'(div_quo_q);
	assign cwnd_sum  = SUM_W'(cwnd_q) + SUM_W'(inc);
	assign cwnd_grow = (cwnd_sum > SUM_W'(WIN_MAX)) ? WIN_MAX : WIN_W'(cwnd_sum);

	// Restoring division of 2^(2F) by cwnd, most significant dividend bit first.
	logic [WIN_W:0]   div_shift;
	logic             div_ge;
	logic [WIN_W:0]   div_sub;
	assign div_shift = {div_rem_q, (div_cnt_q == '0)};
	assign div_ge    = (div_shift >= {1'b0, cwnd_q});
	assign div_sub   = div_shift - {1'b0, cwnd_q};

	// Timeout arithmetic
	logic [RTO_W:0]   rto_dbl;
	logic [RTO_W-1:0] rto_dbl_sat;
	assign rto_dbl     = {rto_q, 1'b0};
	assign rto_dbl_sat = rto_dbl[RTO_W] ? RTO_MAX : rto_dbl[RTO_W-1:0];

	// Committed values
	logic [WIN_W-1:0] cwnd_nxt;
	logic [SS_W-1:0]  ss_nxt;
	logic [RTO_W-1:0] rto_nxt;
	logic [ACK_W-1:0] base_nxt;
	logic [WIN_W-1:0] segs_wide;

	always_comb begin
		cwnd_nxt = cwnd_q;
		ss_nxt   = ssthresh_q;
		rto_nxt  = rto_q;
		base_nxt = snd_una_q;
		if (cmd_q == CMD_TIMEOUT) begin
			if (streak_q >= 2'd2) rto_nxt = rto_dbl_sat;
			ss_nxt   = ss_collapse;
			cwnd_nxt = WIN_ONE;
		end else begin
			if (fast_hit) begin
				ss_nxt   = ss_collapse;
				cwnd_nxt = WIN_ONE;
			end else begin
				cwnd_nxt = cwnd_grow;
			end
			if (ack_q > snd_una_q) base_nxt = ack_q;
		end
	end

	assign segs_wide = cwnd_nxt >> WIN_FRAC_BITS;

	always_comb begin
		status            = '0;
		status.is_timeout = (cmd_q == CMD_TIMEOUT);
		status.need_div   = !fast_hit && !ss_grow;
		status.div_done   = (div_cnt_q == DIV_CNT_W'(DIV_W));
		status.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q      <= '0;
			rttvar_q    <= '0;
			rto_q       <= RTO_RST;
			ssthresh_q  <= SSTHRESH_RST;
			streak_q    <= '0;
			cwnd_q      <= WIN_ONE;
			hist_q[0]   <= HIST_W'(0);
			hist_q[1]   <= HIST_W'(1);
			hist_q[2]   <= HIST_W'(2);
			snd_una_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.wr_ssthresh) ssthresh_q <= cfg.ssthresh_val;
			if (cfg.wr_rto) rto_q <= cfg.rto_val;
			if (cmd.load) div_cnt_q <= '0;
			if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.srtt) srtt_q <= srtt_sum[RTT_BITS+2:3];
			if (cmd.rttvar) rttvar_q <= var_sum[RTT_BITS+1:2];
			if (cmd.rto) rto_q <= rto_calc;
			if (cmd.finish) begin
				cwnd_q      <= cwnd_nxt;
				ssthresh_q  <= ss_nxt;
				rto_q       <= rto_nxt;
				snd_una_q   <= base_nxt;
				if (cmd_q == CMD_TIMEOUT) begin
					if (streak_q != 2'd3) streak_q <= streak_q + 1'b1;
				end else begin
					streak_q <= '0;
					if (!fast_hit) begin
						hist_q[2] <= hist_q[1];
						hist_q[1] <= hist_q[0];
						hist_q[0] <= ack_off;
					end
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= in_cmd;
			ack_q     <= in_ack;
			sample_q  <= sample_sat;
			div_rem_q <= '0;
			div_quo_q <= '0;
		end
		if (cmd.div_step) begin
			div_rem_q <= div_ge ? div_sub[WIN_W-1:0] : div_shift[WIN_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
		end
		if (cmd.finish) begin
			out_window_fixed    <= cwnd_nxt;
			out_window_segments <= (segs_wide > WIN_W'(SEGS_MAX)) ? SEGS_MAX
				: SEGS_W'(segs_wide);
			out_ssthresh        <= ss_nxt;
			out_rto             <= rto_nxt;
			out_fast            <= fast_hit;
			out_resend          <= (cmd_q == CMD_TIMEOUT);
			out_highest_ack     <= base_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/tcp_congestion_and_rto_control.sv
// TCP Reno congestion window and Jacobson RTO controller, top level with register port.
// From transfer in to result valid, a timeout passes the SRTT and commit states; an ack in slow
// start or fast retransmit passes SRTT, VAR, RTO and commit, and one in congestion avoidance
// also the one-bit-per-cycle reciprocal divider. One item at a time: in_stall until commit.
// Reset (arst_n low) loads the register defaults, cwnd 1.0 and empty estimators at once.
module tcp_congestion_and_rto_control import tcpcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [ACK_W-1:0]    ack_number,
	input  logic [SAMPLE_W-1:0] rtt_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WIN_W-1:0]    window_fixed,
	output logic [SEGS_W-1:0]   window_segments,
	output logic [SS_W-1:0]     slow_start_threshold,
	output logic [RTO_W-1:0]    retransmit_timeout,
	output logic                fast_retransmit,
	output logic                resend_oldest,
	output logic [ACK_W-1:0]    highest_ack
);

	logic [SS_W-1:0]     init_ssthresh_q;
	logic [RTO_W-1:0]    init_rto_q;
	logic [MINRTO_W-1:0] min_rto_q;
	logic [SEG_W-1:0]    seg_size_q;

	logic       wr_en;
	cfg_reg_t   reg_sel;
	cfg_t       cfg;
	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ssthresh_q <= SSTHRESH_RST;
			init_rto_q      <= RTO_RST;
			min_rto_q       <= MIN_RTO_RST;
			seg_size_q      <= SEG_SIZE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SSTHRESH: init_ssthresh_q <= pwdata[SS_W-1:0];
				REG_INIT_RTO: init_rto_q      <= pwdata[RTO_W-1:0];
				REG_MIN_RTO:  min_rto_q       <= pwdata[MINRTO_W-1:0];
				REG_SEG_SIZE: seg_size_q      <= pwdata[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SSTHRESH: prdata = DATA_W'(init_ssthresh_q);
			REG_INIT_RTO: prdata = DATA_W'(init_rto_q);
			REG_MIN_RTO:  prdata = DATA_W'(min_rto_q);
			REG_SEG_SIZE: prdata = DATA_W'(seg_size_q);
			default:      prdata = '0;
		endcase
	end

	// A write to either initial value also reloads the live threshold or timeout.
	always_comb begin
		cfg              = '0;
		cfg.wr_ssthresh  = wr_en && (reg_sel == REG_SSTHRESH);
		cfg.wr_rto       = wr_en && (reg_sel == REG_INIT_RTO);
		cfg.ssthresh_val = pwdata[SS_W-1:0];
		cfg.rto_val      = pwdata[RTO_W-1:0];
		cfg.min_rto      = min_rto_q;
		cfg.seg_size     = seg_size_q;
	end

	tcpcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	tcpcc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (dp_cmd),
		.status              (dp_status),
		.cfg                 (cfg),
		.in_cmd              (cmd),
		.in_ack              (ack_number),
		.in_sample           (rtt_sample),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.out_window_fixed    (window_fixed),
		.out_window_segments (window_segments),
		.out_ssthresh        (slow_start_threshold),
		.out_rto             (retransmit_timeout),
		.out_fast            (fast_retransmit),
		.out_resend          (resend_oldest),
		.out_highest_ack     (highest_ack)
	);

	// The block works on one item at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item was in progress");

	// The window never falls below one segment.
	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_segments != '0))
		else $error("window below one segment");

	// Fast retransmit and timeout resend are mutually exclusive.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fast_retransmit && resend_oldest))
		else $error("fast retransmit and resend flagged together");

	// A timeout result always carries a window of exactly one segment.
	a_timeout_window: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && resend_oldest) |-> (window_fixed == WIN_ONE))
		else $error("timeout left the window above one segment");

endmodule

### verif/tb_tcp_congestion_and_rto_control.sv
// Self-checking testbench for tcp_congestion_and_rto_control: Reno window and RTO updates.
// Drives acknowledgements and timeouts under random idling and checks every result against
// a local predictor. Depends on tcpcc_pkg and the RTL top level only.
module tb_tcp_congestion_and_rto_control;
	import tcpcc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [WIN_W-1:0]  win_fixed;
		logic [SEGS_W-1:0] win_segs;
		logic [SS_W-1:0]   ssthresh;
		logic [RTO_W-1:0]  rto;
		logic              fast_rx;
		logic              resend;
		logic [ACK_W-1:0]  snd_una;
	} cc_status_t;

	typedef struct packed {
		logic                c;
		logic [ACK_W-1:0]    ack;
		logic [SAMPLE_W-1:0] smp;
		logic                typed;
		cc_status_t          want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = CMD_ACK;
	logic [ACK_W-1:0]    ack_number = '0;
	logic [SAMPLE_W-1:0] rtt_sample = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [WIN_W-1:0]    window_fixed;
	logic [SEGS_W-1:0]   window_segments;
	logic [SS_W-1:0]     slow_start_threshold;
	logic [RTO_W-1:0]    retransmit_timeout;
	logic                fast_retransmit;
	logic                resend_oldest;
	logic [ACK_W-1:0]    highest_ack;

	// Predicted block state and configuration.
	logic [WIN_W-1:0]     win_q = WIN_ONE;
	logic [SS_W-1:0]      ss_q = SSTHRESH_RST;
	logic [RTT_BITS-1:0]  srtt_q = '0;
	logic [RTT_BITS-1:0]  rttvar_q = '0;
	logic [RTO_W-1:0]     rto_q = RTO_RST;
	logic [1:0]           to_run_q = '0;
	logic signed [63:0]   hist_q [3] = '{64'sd0, 64'sd1, 64'sd2};
	logic [ACK_W-1:0]     base_q = '0;
	logic [MINRTO_W-1:0]  cfg_minrto = MIN_RTO_RST;
	logic [SEG_W-1:0]     cfg_seg = SEG_SIZE_RST;

	cc_status_t status_due [$];
	plan_row_t  opening_rows [18];

	int tx_max_gap = 10;
	int rx_max_stall = 10;
	int n_err = 0;
	int n_items = 0;
	int n_timeouts = 0;
	int n_results = 0;
	int n_fast = 0;
	int n_win_sat = 0;
	int n_settings = 0;
	int quiet_cycles = 0;

	tcp_congestion_and_rto_control DUT (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.cmd                  (cmd),
		.ack_number           (ack_number),
		.rtt_sample           (rtt_sample),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.window_fixed         (window_fixed),
		.window_segments      (window_segments),
		.slow_start_threshold (slow_start_threshold),
		.retransmit_timeout   (retransmit_timeout),
		.fast_retransmit      (fast_retransmit),
		.resend_oldest        (resend_oldest),
		.highest_ack          (highest_ack)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void collapse_window();
		logic [63:0] half;
		half = win_q >> (WIN_FRAC_BITS + 1);
		if (half < SS_MIN) half = SS_MIN;
		ss_q = (half > SS_MAX) ? SS_MAX : SS_W'(half);
		win_q = WIN_ONE;
	endfunction

	function automatic cc_status_t reno_rto_update(logic c, logic [ACK_W-1:0] ack,
			logic [SAMPLE_W-1:0] smp);
		cc_status_t st;
		logic [63:0] srtt_n, diff, rto_n, inc, sum, whole;
		logic signed [63:0] d;
		logic fast;
		fast = 1'b0;
		if (c == CMD_ACK) begin
			to_run_q = '0;
			srtt_n = (64'd7 * srtt_q + smp) >> 3;
			diff = (srtt_n >= smp) ? srtt_n - smp : smp - srtt_n;
			rttvar_q = RTT_BITS'((64'd3 * rttvar_q + diff) >> 2);
			srtt_q = RTT_BITS'(srtt_n);
			rto_n = srtt_n + 64'd4 * rttvar_q;
			if (rto_n < cfg_minrto) rto_n = cfg_minrto;
			rto_q = (rto_n > RTO_MAX) ? RTO_MAX : RTO_W'(rto_n);
			// The history holds ack numbers less one segment, so they may go negative.
			d = $signed({32'd0, ack}) - $signed({48'd0, cfg_seg});
			if (d == hist_q[0] && hist_q[0] == hist_q[1] && hist_q[1] == hist_q[2]) begin
				collapse_window();
				fast = 1'b1;
			end else begin
				hist_q[2] = hist_q[1];
				hist_q[1] = hist_q[0];
				hist_q[0] = d;
				whole = win_q >> WIN_FRAC_BITS;
				if (whole <= ss_q) inc = WIN_ONE;
				else inc = (win_q != '0) ? (64'd1 << (2 * WIN_FRAC_BITS)) / win_q : WIN_MAX;
				sum = win_q + inc;
				win_q = (sum > WIN_MAX) ? WIN_MAX : WIN_W'(sum);
			end
			if (ack > base_q) base_q = ack;
		end else begin
			if (to_run_q >= 2)
				rto_q = (64'd2 * rto_q > RTO_MAX) ? RTO_MAX : RTO_W'(64'd2 * rto_q);
			if (to_run_q < 3) to_run_q = to_run_q + 1'b1;
			collapse_window();
		end
		st.win_fixed = win_q;
		st.win_segs = ((win_q >> WIN_FRAC_BITS) > SEGS_MAX) ? SEGS_MAX :
			SEGS_W'(win_q >> WIN_FRAC_BITS);
		st.ssthresh = ss_q;
		st.rto = rto_q;
		st.fast_rx = fast;
		st.resend = (c == CMD_TIMEOUT);
		st.snd_una = base_q;
		return st;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_rtt();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return SAMPLE_W'(srtt_q + $urandom_range(0, 40));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("result %0d: %s is %0h, predicted %0h", n_results, field, got, want);
		n_err++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(logic c, logic [ACK_W-1:0] a, logic [SAMPLE_W-1:0] s,
			logic typed = 1'b0, cc_status_t want = '0);
		cc_status_t st;
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		ack_number <= a;
		rtt_sample <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		st = reno_rto_update(c, a, s);
		status_due.push_back(typed ? want : st);
		n_items++;
		if (c == CMD_TIMEOUT) n_timeouts++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(cfg_reg_t r, logic [DATA_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (r)
			REG_SSTHRESH: ss_q = SS_W'(v);
			REG_INIT_RTO: rto_q = RTO_W'(v);
			REG_MIN_RTO:  cfg_minrto = MINRTO_W'(v);
			REG_SEG_SIZE: cfg_seg = SEG_W'(v);
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_setting(logic [SS_W-1:0] ss, logic [RTO_W-1:0] rto,
			logic [MINRTO_W-1:0] mrto, logic [SEG_W-1:0] seg);
		drain();
		reg_write(REG_SSTHRESH, DATA_W'(ss));
		reg_write(REG_INIT_RTO, DATA_W'(rto));
		reg_write(REG_MIN_RTO, DATA_W'(mrto));
		reg_write(REG_SEG_SIZE, DATA_W'(seg));
		n_settings++;
	endtask

	// Mostly in-order acknowledgement runs, duplicate runs that are mostly long enough to trigger a
	// fast retransmit, and timeout runs that mostly reach the doubling; a little pure noise besides.
	task automatic random_traffic(int n_wanted);
		int done, len, kind;
		logic [ACK_W-1:0] a;
		done = 0;
		while (done < n_wanted) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = $urandom_range(1, 8);
				a = base_q;
				repeat (len) begin
					a = a + cfg_seg * $urandom_range(1, 4);
					send_item(CMD_ACK, a, pick_rtt());
				end
			end else if (kind < 75) begin
				len = $urandom_range(3, 6);
				a = ($urandom_range(0, 1) == 0) ? base_q : ACK_W'($urandom);
				repeat (len) send_item(CMD_ACK, a, pick_rtt());
			end else if (kind < 90) begin
				len = $urandom_range(1, 8);
				repeat (len) send_item(CMD_TIMEOUT, ACK_W'($urandom), SAMPLE_W'($urandom));
			end else begin
				len = 1;
				send_item(($urandom_range(0, 1) == 0) ? CMD_ACK : CMD_TIMEOUT,
					ACK_W'($urandom), SAMPLE_W'($urandom));
			end
			done += len;
		end
	endtask

	initial begin : result_sink
		cc_status_t w;
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = $urandom_range(0, rx_max_stall);
			@(negedge clk);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (status_due.size() == 0) begin
				report_mismatch("window_fixed with nothing pending", window_fixed, '0);
			end else begin
				w = status_due.pop_front();
				if (window_fixed !== w.win_fixed)
					report_mismatch("window_fixed", window_fixed, w.win_fixed);
				if (window_segments !== w.win_segs)
					report_mismatch("window_segments", window_segments, w.win_segs);
				if (slow_start_threshold !== w.ssthresh)
					report_mismatch("slow_start_threshold", slow_start_threshold, w.ssthresh);
				if (retransmit_timeout !== w.rto)
					report_mismatch("retransmit_timeout", retransmit_timeout, w.rto);
				if (fast_retransmit !== w.fast_rx)
					report_mismatch("fast_retransmit", fast_retransmit, w.fast_rx);
				if (resend_oldest !== w.resend)
					report_mismatch("resend_oldest", resend_oldest, w.resend);
				if (highest_ack !== w.snd_una)
					report_mismatch("highest_ack", highest_ack, w.snd_una);
			end
			if (fast_retransmit === 1'b1) n_fast++;
			if (window_fixed === WIN_MAX) n_win_sat++;
			n_results++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("no transfer for %0d cycles", STALL_LIMIT);
			$display("tb_tcp_congestion_and_rto_control: errors");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ACK_W-1:0] climb_ack;
		// Timeouts straight after reset show the default timeout and the doubling from the
		// third one on; the duplicate run at 5000 gives two fast retransmits in a row.
		opening_rows = '{
			'{CMD_TIMEOUT, 32'd0, 16'd0, 1'b1,
				'{32'h0001_0000, 16'd1, 16'd2, 24'd3000, 1'b0, 1'b1, 32'd0}},
			'{CMD_TIMEOUT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
				'{32'h0001_0000, 16'd1, 16'd2, 24'd3000, 1'b0, 1'b1, 32'd0}},
			'{CMD_TIMEOUT, 32'd0, 16'd0, 1'b1,
				'{32'h0001_0000, 16'd1, 16'd2, 24'd6000, 1'b0, 1'b1, 32'd0}},
			'{CMD_TIMEOUT, 32'd0, 16'd0, 1'b1,
				'{32'h0001_0000, 16'd1, 16'd2, 24'd12000, 1'b0, 1'b1, 32'd0}},
			'{CMD_ACK, 32'd0, 16'hFFFF, 1'b1,
				'{32'h0002_0000, 16'd2, 16'd2, 24'd65535, 1'b0, 1'b0, 32'd0}},
			'{CMD_ACK, 32'd0, 16'd0, 1'b0, '0},
			'{CMD_ACK, 32'd100, 16'd0, 1'b0, '0},
			'{CMD_ACK, 32'd5000, 16'd40, 1'b0, '0},
			'{CMD_ACK, 32'd5000, 16'd40, 1'b0, '0},
			'{CMD_ACK, 32'd5000, 16'd40, 1'b0, '0},
			'{CMD_ACK, 32'd5000, 16'd40, 1'b0, '0},
			'{CMD_ACK, 32'd5000, 16'd40, 1'b0, '0},
			'{CMD_ACK, 32'd6024, 16'd300, 1'b0, '0},
			'{CMD_ACK, 32'd7048, 16'hFFFF, 1'b0, '0},
			'{CMD_ACK, 32'd8072, 16'd0, 1'b0, '0},
			'{CMD_ACK, 32'd9096, 16'd120, 1'b0, '0},
			'{CMD_ACK, 32'd10120, 16'd120, 1'b0, '0},
			'{CMD_TIMEOUT, 32'd0, 16'd0, 1'b0, '0}
		};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[i])
			send_item(opening_rows[i].c, opening_rows[i].ack, opening_rows[i].smp,
				opening_rows[i].typed, opening_rows[i].want);

		apply_setting(SS_W'(2), RTO_W'(1), MINRTO_W'(0), SEG_W'(1));
		random_traffic(90);
		apply_setting(SS_MAX, RTO_MAX, '1, '1);
		random_traffic(90);
		// Below the legal range: a zero threshold, timeout and segment size.
		apply_setting('0, '0, '0, '0);
		random_traffic(90);
		apply_setting(SS_W'($urandom_range(2, 200)), RTO_W'($urandom_range(1, 24'hFF_FFFF)),
			MINRTO_W'($urandom_range(0, 500)), SEG_W'($urandom_range(1, 4096)));
		random_traffic(90);
		apply_setting(SSTHRESH_RST, RTO_RST, MIN_RTO_RST, SEG_SIZE_RST);
		random_traffic(90);

		// With the largest threshold every acknowledgement adds a whole segment, so the
		// window climbs steadily through a long slow start.
		apply_setting(SS_MAX, RTO_RST, MIN_RTO_RST, SEG_W'(1));
		climb_ack = '0;
		repeat (32) begin
			send_item(CMD_ACK, climb_ack, pick_rtt());
			climb_ack++;
		end

		// Congestion avoidance on the grown window, then the largest ack number last,
		// since the highest ack never falls again.
		apply_setting(SS_MIN, RTO_W'(5000), MIN_RTO_RST, SEG_SIZE_RST);
		repeat (3) begin
			send_item(CMD_ACK, climb_ack, pick_rtt());
			climb_ack += SEG_SIZE_RST;
		end
		repeat (3) send_item(CMD_TIMEOUT, ACK_W'($urandom), SAMPLE_W'($urandom));
		send_item(CMD_ACK, '1, '1);
		send_item(CMD_ACK, '1, '0);

		drain();
		repeat (60) @(posedge clk);
		$display("%0d events sent (%0d timeouts) over %0d register settings and a long climb",
			n_items, n_timeouts, n_settings);
		$display("%0d results checked, %0d fast retransmits, %0d with a saturated window",
			n_results, n_fast, n_win_sat);
		if (n_err == 0) begin
			$display("tb_tcp_congestion_and_rto_control: clean");
		end else begin
			$display("tb_tcp_congestion_and_rto_control: errors");
		end
		$finish;
	end

endmodule
